### rtl/rot_pkg.sv
package rot_pkg;

    // field widths of one request and one result
    localparam int REQ_W  = 3;
    localparam int ID_W   = 8;
    localparam int POS_W  = 16;
    localparam int SIZE_W = 15;
    localparam int STAT_W = 2;
    // edge sums need one bit more than a position
    localparam int EDGE_W = POS_W + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_POS  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_SIZE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LOOKUP   = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_REPLACED  = 2'd3;

    // one table slot
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
    } rot_entry_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_EXEC,
        S_MOVE_RD,
        S_MOVE_WR,
        S_APPEND,
        S_QUERY,
        S_RESP
    } rot_state_t;

endpackage

### rtl/rot_cmd_if.sv
interface rot_cmd_if;
    import rot_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [ID_W-1:0]          entry_id;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0]        size_w;
    logic [SIZE_W-1:0]        size_h;

    modport source (
        output valid, req_type, entry_id, pos_x, pos_y, size_w, size_h,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_id, pos_x, pos_y, size_w, size_h,
        output ready
    );

endinterface

### rtl/rot_res_if.sv
interface rot_res_if;
    import rot_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic                     hit_found;
    logic [ID_W-1:0]          hit_id;
    logic signed [POS_W-1:0]  rect_x;
    logic signed [POS_W-1:0]  rect_y;
    logic [SIZE_W-1:0]        rect_w;
    logic [SIZE_W-1:0]        rect_h;

    modport source (
        output valid, status, hit_found, hit_id, rect_x, rect_y, rect_w, rect_h,
        input  ready
    );

    modport sink (
        input  valid, status, hit_found, hit_id, rect_x, rect_y, rect_w, rect_h,
        output ready
    );

endinterface

### rtl/rect_overlap_table_core.sv
// channel | modport | role
// --------+---------+----------------------------------------------------
// cmd     | sink    | request: req_type, entry_id, pos_x/y, size_w/h
// res     | source  | one result per request: status, hit, looked-up rect
//
// a request first searches the table for its id, one slot per cycle through
// the single read port of the slot memory, then executes; remove and a
// replacing add move the last slot into the found one, a replacing add then
// appends, and a query walks the table again with the one overlap comparator
// reset empties the table at once (slot count to zero); no clearing pass
// cmd is taken only while the sequencer is idle; a finished result waits in
// the output register, and the next request may start meanwhile
module rect_overlap_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rot_cmd_if.sink   cmd,
    rot_res_if.source res
);
    import rot_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // control state
    rot_state_t       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic             out_valid_reg, out_valid_next;

    // payload state
    logic [AW-1:0]           pa_reg, pa_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic [REQ_W-1:0]        rq_reg, rq_next;
    rot_entry_t              nw_reg, nw_next;
    rot_entry_t              cur_reg, cur_next;
    logic signed [EDGE_W-1:0] r0_reg, r0_next;
    logic signed [EDGE_W-1:0] b0_reg, b0_next;
    logic [STAT_W-1:0]       rs_status_reg, rs_status_next;
    logic                    rs_hit_reg, rs_hit_next;
    logic [ID_W-1:0]         rs_hid_reg, rs_hid_next;
    rot_entry_t              rs_rect_reg, rs_rect_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic                    out_hit_reg, out_hit_next;
    logic [ID_W-1:0]         out_hid_reg, out_hid_next;
    rot_entry_t              out_rect_reg, out_rect_next;

    // slot memory
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    rot_entry_t       ram_wdata;
    logic [AW-1:0]    ram_raddr;
    rot_entry_t       ram_rdata;

    logic [CW-1:0]    last_slot;

    // overlap comparator against the slot just read
    logic signed [EDGE_W-1:0] l0, t0, l1, t1, r1, b1;
    logic                     overlap;

    rot_ram #(
        .WIDTH ($bits(rot_entry_t)),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign last_slot = count_reg - CW'(1);

    // strict overlap; touching edges do not count
    always_comb
    begin
        l0 = {cur_reg.x[POS_W-1], cur_reg.x};
        t0 = {cur_reg.y[POS_W-1], cur_reg.y};
        l1 = {ram_rdata.x[POS_W-1], ram_rdata.x};
        t1 = {ram_rdata.y[POS_W-1], ram_rdata.y};
        r1 = l1 + $signed({2'b00, ram_rdata.w});
        b1 = t1 + $signed({2'b00, ram_rdata.h});
        overlap = !((b0_reg <= t1) || (t0 >= b1) || (l0 >= r1) || (r0_reg <= l1));
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        pa_next        = pa_reg;
        slot_next      = slot_reg;
        rq_next        = rq_reg;
        nw_next        = nw_reg;
        cur_next       = cur_reg;
        r0_next        = r0_reg;
        b0_next        = b0_reg;
        rs_status_next = rs_status_reg;
        rs_hit_next    = rs_hit_reg;
        rs_hid_next    = rs_hid_reg;
        rs_rect_next   = rs_rect_reg;
        out_status_next = out_status_reg;
        out_hit_next   = out_hit_reg;
        out_hid_next   = out_hid_reg;
        out_rect_next  = out_rect_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = nw_reg;
        ram_raddr      = idx_reg[AW-1:0];
        cmd.ready      = (state_reg == S_IDLE);

        // result taken downstream
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    rq_next        = cmd.req_type;
                    nw_next.id     = cmd.entry_id;
                    nw_next.x      = cmd.pos_x;
                    nw_next.y      = cmd.pos_y;
                    nw_next.w      = cmd.size_w;
                    nw_next.h      = cmd.size_h;
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    found_next     = 1'b0;
                    rs_status_next = ST_OK;
                    rs_hit_next    = 1'b0;
                    rs_hid_next    = '0;
                    rs_rect_next   = '0;
                    state_next     = S_FIND;
                end
            end

            // id search, one slot read per cycle
            S_FIND:
            begin
                if (pend_reg && (ram_rdata.id == nw_reg.id))
                begin
                    found_next = 1'b1;
                    slot_next  = pa_reg;
                    cur_next   = ram_rdata;
                    pend_next  = 1'b0;
                    state_next = S_EXEC;
                end
                else if (idx_reg == count_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = S_EXEC;
                end
                else
                begin
                    pend_next = 1'b1;
                    pa_next   = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
            end

            S_EXEC:
            begin
                state_next = S_RESP;
                unique case (rq_reg)
                    REQ_ADD:
                    begin
                        if (found_reg)
                        begin
                            rs_status_next = ST_REPLACED;
                            state_next     = S_MOVE_RD;
                        end
                        else if (count_reg == CW'(ENTRIES))
                        begin
                            rs_status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            state_next = S_MOVE_RD;
                        end
                        else
                        begin
                            rs_status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_SET_POS:
                    begin
                        if (found_reg)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = cur_reg;
                            ram_wdata.x = nw_reg.x;
                            ram_wdata.y = nw_reg.y;
                        end
                        else
                        begin
                            rs_status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_SET_SIZE:
                    begin
                        if (found_reg)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = cur_reg;
                            ram_wdata.w = nw_reg.w;
                            ram_wdata.h = nw_reg.h;
                        end
                        else
                        begin
                            rs_status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_QUERY:
                    begin
                        if (found_reg)
                        begin
                            r0_next    = l0 + $signed({2'b00, cur_reg.w});
                            b0_next    = t0 + $signed({2'b00, cur_reg.h});
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_QUERY;
                        end
                        else
                        begin
                            rs_status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            rs_rect_next    = cur_reg;
                            rs_rect_next.id = '0;
                        end
                        else
                        begin
                            rs_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        rs_status_next = ST_OK;
                    end
                endcase
            end

            // swap-pop: fetch the last slot
            S_MOVE_RD:
            begin
                ram_raddr  = last_slot[AW-1:0];
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_reg;
                ram_wdata = ram_rdata;
                if (rq_reg == REQ_ADD)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    count_next = last_slot;
                    state_next = S_RESP;
                end
            end

            // replacing add: new rectangle lands in the old last slot
            S_APPEND:
            begin
                ram_we     = 1'b1;
                ram_waddr  = last_slot[AW-1:0];
                ram_wdata  = nw_reg;
                state_next = S_RESP;
            end

            // overlap walk in table order
            S_QUERY:
            begin
                if (pend_reg && (ram_rdata.id != nw_reg.id) && overlap)
                begin
                    rs_hit_next = 1'b1;
                    rs_hid_next = ram_rdata.id;
                    pend_next   = 1'b0;
                    state_next  = S_RESP;
                end
                else if (idx_reg == count_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = S_RESP;
                end
                else
                begin
                    pend_next = 1'b1;
                    pa_next   = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
            end

            // hand the result to the output register once it is free
            S_RESP:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rs_status_reg;
                    out_hit_next    = rs_hit_reg;
                    out_hid_next    = rs_hid_reg;
                    out_rect_next   = rs_rect_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pa_reg         <= pa_next;
        slot_reg       <= slot_next;
        rq_reg         <= rq_next;
        nw_reg         <= nw_next;
        cur_reg        <= cur_next;
        r0_reg         <= r0_next;
        b0_reg         <= b0_next;
        rs_status_reg  <= rs_status_next;
        rs_hit_reg     <= rs_hit_next;
        rs_hid_reg     <= rs_hid_next;
        rs_rect_reg    <= rs_rect_next;
        out_status_reg <= out_status_next;
        out_hit_reg    <= out_hit_next;
        out_hid_reg    <= out_hid_next;
        out_rect_reg   <= out_rect_next;
    end

    // result port
    assign res.valid     = out_valid_reg;
    assign res.status    = out_status_reg;
    assign res.hit_found = out_hit_reg;
    assign res.hit_id    = out_hid_reg;
    assign res.rect_x    = out_rect_reg.x;
    assign res.rect_y    = out_rect_reg.y;
    assign res.rect_w    = out_rect_reg.w;
    assign res.rect_h    = out_rect_reg.h;

`ifndef SYNTH
    // table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("slot count beyond table depth");

    // one request moves the slot count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + CW'(1)) ||
         (count_reg == $past(count_reg) - CW'(1))))
        else $error("slot count jumped");

    // a pending read during a walk is always a live slot
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && ((state_reg == S_FIND) || (state_reg == S_QUERY))) |->
        ({1'b0, pa_reg} < {1'b0, count_reg}))
        else $error("walk read beyond last slot");

    // a hit is only reported with ok status
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.hit_found) |-> (res.status == ST_OK))
        else $error("hit reported with error status");
`endif

endmodule

### rtl/rot_ram.sv
module rot_ram #(
    parameter int WIDTH = 70,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
